### design/psema_pkg.sv
// Shared types, constants and codes for the pedal scaler and averaging block.
package psema_pkg;

	localparam int SAMPLE_BITS = 12;
	localparam int VALUE_W     = 16;
	localparam int ALPHA_W     = 17;
	localparam int FRAC_W      = 16;
	localparam int ACC_W       = VALUE_W + FRAC_W;
	localparam int SUM_W       = 32;
	localparam int COUNT_W     = 8;
	localparam int MAG_W       = SAMPLE_BITS + VALUE_W;
	localparam int PRODA_W     = ALPHA_W + VALUE_W;
	localparam int PRODB_W     = ALPHA_W + ACC_W;
	localparam int ROUND_HALF  = 1 << (FRAC_W - 1);
	localparam int ALPHA_ONE   = 1 << FRAC_W;

	// Shared divider: two quotient bits per cycle.
	localparam int DIVIDEND_W  = SUM_W;
	localparam int DIVISOR_W   = SAMPLE_BITS;
	localparam int DIV_STEPS   = DIVIDEND_W / 2;
	localparam int DIV_CNT_W   = $clog2(DIV_STEPS);

	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	localparam int CFG_INDEX_W = 3;
	localparam int CFG_DATA_W  = ALPHA_W;

	localparam logic OP_SAMPLE = 1'b0;
	localparam logic OP_TICK   = 1'b1;

	typedef enum logic [CFG_INDEX_W-1:0] {
		CFG_ZERO_POSITION = 3'd0,
		CFG_FULL_POSITION = 3'd1,
		CFG_RANGE_LOW     = 3'd2,
		CFG_RANGE_HIGH    = 3'd3,
		CFG_ALPHA         = 3'd4
	} cfg_index_t;

	typedef enum logic [1:0] {
		KIND_INSIDE = 2'd0,
		KIND_BELOW  = 2'd1,
		KIND_ABOVE  = 2'd2,
		KIND_TICK   = 2'd3
	} kind_t;

	typedef struct packed {
		logic [SAMPLE_BITS-1:0] zero_position;
		logic [SAMPLE_BITS-1:0] full_position;
		logic [VALUE_W-1:0]     range_low;
		logic [VALUE_W-1:0]     range_high;
		logic [ALPHA_W-1:0]     alpha;
	} cfg_t;

	// One classified word as it waits between front and back.
	typedef struct packed {
		kind_t                  kind;
		logic                   neg;
		logic [SAMPLE_BITS-1:0] span;
		logic [MAG_W-1:0]       mag;
	} item_t;

endpackage

### design/psema_front.sv
// Front end: accepts input words and classifies them against the window.
module psema_front (
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic                             opcode,
	input  logic [psema_pkg::SAMPLE_BITS-1:0] raw_sample,
	input  psema_pkg::cfg_t                  cfg,
	input  logic                             queue_full,
	output logic                             push,
	output psema_pkg::item_t                 item
);
	import psema_pkg::*;

	logic [SAMPLE_BITS-1:0] offs;
	logic [VALUE_W-1:0]     abs_diff;
	logic                   neg;

	assign in_ready = !queue_full;
	assign push     = in_valid && in_ready;

	assign neg      = cfg.range_high < cfg.range_low;
	assign abs_diff = neg ? (cfg.range_low - cfg.range_high) : (cfg.range_high - cfg.range_low);
	assign offs     = raw_sample - cfg.zero_position;

	always_comb begin
		item.neg  = neg;
		item.span = cfg.full_position - cfg.zero_position;
		// Magnitude of offset times range difference; the sign is applied after the divide.
		item.mag  = MAG_W'(offs) * MAG_W'(abs_diff);
		if (opcode == OP_TICK) begin
			item.kind = KIND_TICK;
		end else if (raw_sample < cfg.zero_position) begin
			item.kind = KIND_BELOW;
		end else if (raw_sample <= cfg.full_position) begin
			item.kind = KIND_INSIDE;
		end else begin
			item.kind = KIND_ABOVE;
		end
	end

endmodule

### design/psema_fifo.sv
// Short queue of classified words between the front and back ends.
module psema_fifo (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  psema_pkg::item_t wr_item,
	input  logic             pop,
	output logic             full,
	output logic             valid,
	output psema_pkg::item_t rd_item
);
	import psema_pkg::*;

	item_t             entries_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;

	assign full    = count_q == QCNT_W'(QUEUE_DEPTH);
	assign valid   = count_q != '0;
	assign rd_item = entries_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entries_q[wr_ptr_q] <= wr_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + QPTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + QPTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + QCNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - QCNT_W'(1);
			end
		end
	end

endmodule

### design/psema_div.sv
// Restoring unsigned divider that retires two quotient bits per cycle.
module psema_div (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	input  logic [psema_pkg::DIVIDEND_W-1:0] dividend,
	input  logic [psema_pkg::DIVISOR_W-1:0]  divisor,
	output logic                             done,
	output logic [psema_pkg::DIVIDEND_W-1:0] quotient
);
	import psema_pkg::*;

	logic [DIVIDEND_W-1:0] work_q;
	logic [DIVISOR_W-1:0]  rem_q;
	logic [DIVISOR_W-1:0]  divisor_q;
	logic [DIV_CNT_W-1:0]  step_q;
	logic                  busy_q;
	logic                  done_q;

	logic [DIVISOR_W:0]    r1, d1, r2, d2;
	logic [DIVISOR_W-1:0]  m1, m2;
	logic                  ge1, ge2;

	assign done     = done_q;
	assign quotient = work_q;

	// The dividend shifts out of the top of work_q while quotient bits shift in below.
	always_comb begin
		r1  = {rem_q, work_q[DIVIDEND_W-1]};
		d1  = r1 - {1'b0, divisor_q};
		ge1 = r1 >= {1'b0, divisor_q};
		m1  = ge1 ? d1[DIVISOR_W-1:0] : r1[DIVISOR_W-1:0];
		r2  = {m1, work_q[DIVIDEND_W-2]};
		d2  = r2 - {1'b0, divisor_q};
		ge2 = r2 >= {1'b0, divisor_q};
		m2  = ge2 ? d2[DIVISOR_W-1:0] : r2[DIVISOR_W-1:0];
	end

	always_ff @(posedge clk) begin
		if (start) begin
			work_q    <= dividend;
			rem_q     <= '0;
			divisor_q <= divisor;
		end else if (busy_q) begin
			work_q <= {work_q[DIVIDEND_W-3:0], ge1, ge2};
			rem_q  <= m2;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				step_q <= step_q + DIV_CNT_W'(1);
				if (step_q == DIV_CNT_W'(DIV_STEPS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

`ifndef ASSERT_OFF
	a_no_restart: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> !start) else $error("divider started while busy");
`endif

endmodule

### design/psema_back.sv
// Back end: divide, filter, period bookkeeping and the output register.
module psema_back (
	input  logic                          clk,
	input  logic                          arst_n,
	input  psema_pkg::cfg_t               cfg,
	input  logic                          item_valid,
	input  psema_pkg::item_t              item,
	output logic                          pop,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [psema_pkg::VALUE_W-1:0] scaled_value,
	output logic [psema_pkg::VALUE_W-1:0] smoothed_value,
	output logic [psema_pkg::VALUE_W-1:0] period_average
);
	import psema_pkg::*;

	typedef enum logic [6:0] {
		ST_IDLE = 7'b0000001,
		ST_DIV  = 7'b0000010,
		ST_MAP  = 7'b0000100,
		ST_MUL  = 7'b0001000,
		ST_ACC  = 7'b0010000,
		ST_FILT = 7'b0100000,
		ST_EMIT = 7'b1000000
	} state_t;

	state_t               state_q;
	kind_t                kind_q;
	logic                 neg_q;
	logic [VALUE_W-1:0]   quo_q;
	logic [ACC_W-1:0]     acc_q;
	logic                 seeded_q;
	logic [VALUE_W-1:0]   last_scaled_q;
	logic [VALUE_W-1:0]   last_filtered_q;
	logic [SUM_W-1:0]     sum_q;
	logic [COUNT_W-1:0]   count_q;
	logic [VALUE_W-1:0]   avg_q;
	logic [PRODA_W-1:0]   prod_a_q;
	logic [PRODB_W-1:0]   prod_b_q;
	logic                 out_valid_q;
	logic [VALUE_W-1:0]   scaled_q;
	logic [VALUE_W-1:0]   filtered_q;
	logic [VALUE_W-1:0]   average_q;

	logic                  div_start;
	logic [DIVIDEND_W-1:0] div_dividend;
	logic [DIVISOR_W-1:0]  div_divisor;
	logic                  div_done;
	logic [DIVIDEND_W-1:0] div_quotient;

	logic [ALPHA_W-1:0]   alpha_eff;
	logic [ALPHA_W-1:0]   alpha_rest;
	logic [VALUE_W-1:0]   mapped;
	logic [PRODB_W-1:0]   prod_b_rnd;
	logic [ACC_W:0]       acc_rnd;
	logic                 emit_go;

	assign out_valid      = out_valid_q;
	assign scaled_value   = scaled_q;
	assign smoothed_value = filtered_q;
	assign period_average = average_q;

	assign pop     = (state_q == ST_IDLE) && item_valid;
	assign emit_go = (state_q == ST_EMIT) && (!out_valid_q || out_ready);

	always_comb begin
		div_start    = 1'b0;
		div_dividend = DIVIDEND_W'(item.mag);
		div_divisor  = item.span;
		if (item.kind == KIND_TICK) begin
			div_dividend = sum_q;
			div_divisor  = DIVISOR_W'(count_q);
			div_start    = pop && (count_q != '0);
		end else if (item.kind == KIND_INSIDE) begin
			div_start    = pop && (item.span != '0);
		end
	end

	psema_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.done     (div_done),
		.quotient (div_quotient)
	);

	assign alpha_eff  = (cfg.alpha > ALPHA_W'(ALPHA_ONE)) ? ALPHA_W'(ALPHA_ONE) : cfg.alpha;
	assign alpha_rest = ALPHA_W'(ALPHA_ONE) - alpha_eff;
	assign mapped     = neg_q ? (cfg.range_low - quo_q) : (cfg.range_low + quo_q);
	assign prod_b_rnd = prod_b_q + PRODB_W'(ROUND_HALF);
	assign acc_rnd    = {1'b0, acc_q} + (ACC_W + 1)'(ROUND_HALF);

	always_ff @(posedge clk) begin
		if (pop) begin
			kind_q <= item.kind;
			neg_q  <= item.neg;
		end
		if (state_q == ST_MUL) begin
			prod_a_q <= PRODA_W'(alpha_eff) * PRODA_W'(last_scaled_q);
			prod_b_q <= PRODB_W'(alpha_rest) * PRODB_W'(acc_q);
		end
		if (pop && item.kind == KIND_INSIDE && item.span == '0) begin
			quo_q <= '0;
		end else if (state_q == ST_DIV && div_done) begin
			quo_q <= div_quotient[VALUE_W-1:0];
		end
		if (emit_go) begin
			scaled_q   <= last_scaled_q;
			filtered_q <= last_filtered_q;
			average_q  <= avg_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q         <= ST_IDLE;
			acc_q           <= '0;
			seeded_q        <= 1'b0;
			last_scaled_q   <= '0;
			last_filtered_q <= '0;
			sum_q           <= '0;
			count_q         <= '0;
			avg_q           <= '0;
			out_valid_q     <= 1'b0;
		end else begin
			if (emit_go) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (item_valid) begin
						case (item.kind)
							KIND_INSIDE: begin
								state_q <= (item.span != '0) ? ST_DIV : ST_MAP;
							end
							KIND_BELOW: begin
								last_scaled_q   <= cfg.range_low;
								last_filtered_q <= cfg.range_low;
								state_q         <= ST_EMIT;
							end
							KIND_ABOVE: begin
								last_scaled_q   <= cfg.range_high;
								last_filtered_q <= cfg.range_high;
								state_q         <= ST_EMIT;
							end
							KIND_TICK: begin
								if (count_q != '0) begin
									state_q <= ST_DIV;
								end else begin
									avg_q   <= '0;
									state_q <= ST_EMIT;
								end
							end
							default: begin
								state_q <= ST_IDLE;
							end
						endcase
					end
				end
				ST_DIV: begin
					if (div_done) begin
						if (kind_q == KIND_TICK) begin
							avg_q   <= (|div_quotient[DIVIDEND_W-1:VALUE_W]) ? '1 :
								div_quotient[VALUE_W-1:0];
							state_q <= ST_EMIT;
						end else begin
							state_q <= ST_MAP;
						end
					end
				end
				ST_MAP: begin
					last_scaled_q <= mapped;
					if (!seeded_q) begin
						acc_q    <= {mapped, FRAC_W'(0)};
						seeded_q <= 1'b1;
						state_q  <= ST_FILT;
					end else begin
						state_q  <= ST_MUL;
					end
				end
				ST_MUL: begin
					state_q <= ST_ACC;
				end
				ST_ACC: begin
					// The new-sample term has no fraction, so only the old term needs rounding.
					acc_q   <= prod_a_q[ACC_W-1:0] + prod_b_rnd[FRAC_W+ACC_W-1:FRAC_W];
					state_q <= ST_FILT;
				end
				ST_FILT: begin
					last_filtered_q <= acc_rnd[ACC_W] ? '1 : acc_rnd[ACC_W-1:FRAC_W];
					state_q         <= ST_EMIT;
				end
				ST_EMIT: begin
					if (emit_go) begin
						if (kind_q == KIND_TICK) begin
							sum_q   <= '0;
							count_q <= '0;
						end else begin
							sum_q   <= sum_q + SUM_W'(last_scaled_q);
							count_q <= count_q + COUNT_W'(1);
						end
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

`ifndef ASSERT_OFF
	a_done_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> (state_q == ST_DIV)) else $error("divider finished outside the divide state");
	a_seed_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		!$fell(seeded_q)) else $error("filter seed flag dropped");
	a_mul_seeded: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_MUL) |-> seeded_q) else $error("filter blend on an unseeded filter");
	a_tick_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(emit_go && kind_q == KIND_TICK) |=> (count_q == '0) && (sum_q == '0))
		else $error("period tick did not clear sum and count");
`endif

endmodule

### design/pedal_sensor_scale_ema_average.sv
// Top level of the pedal scaler with moving-average filter and period average.
//
// Channel   Handshake              Word
// in        in_valid / in_ready    opcode, raw_sample
// out       out_valid / out_ready  scaled_value, smoothed_value, period_average
// cfg       cfg_valid / cfg_ready  cfg_index, cfg_data
//
// An in-window sample leaves the queue, passes the divider, then map, multiply, accumulate,
// round and output load before the output handshake; the first sample skips multiply and
// accumulate, and a zero-width window skips the divider. Out-of-window samples go straight
// to output load; a tick uses the divider unless the count is zero.
// Reset is asynchronous and active low; no clearing pass is needed after it.
// A held output word stalls the back end; the two-word queue then fills and drops in_ready.
module pedal_sensor_scale_ema_average (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic                                opcode,
	input  logic [psema_pkg::SAMPLE_BITS-1:0]   raw_sample,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic [psema_pkg::VALUE_W-1:0]       scaled_value,
	output logic [psema_pkg::VALUE_W-1:0]       smoothed_value,
	output logic [psema_pkg::VALUE_W-1:0]       period_average,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [psema_pkg::CFG_INDEX_W-1:0]   cfg_index,
	input  logic [psema_pkg::CFG_DATA_W-1:0]    cfg_data
);
	import psema_pkg::*;

	cfg_t  cfg_q;
	logic  push;
	logic  pop;
	logic  queue_full;
	logic  queue_valid;
	item_t front_item;
	item_t queue_item;

	// The register file never stalls; writes outside the list are dropped.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.zero_position <= '0;
			cfg_q.full_position <= '1;
			cfg_q.range_low     <= '0;
			cfg_q.range_high    <= VALUE_W'(100);
			cfg_q.alpha         <= ALPHA_W'(6554);
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_ZERO_POSITION: cfg_q.zero_position <= cfg_data[SAMPLE_BITS-1:0];
				CFG_FULL_POSITION: cfg_q.full_position <= cfg_data[SAMPLE_BITS-1:0];
				CFG_RANGE_LOW:     cfg_q.range_low     <= cfg_data[VALUE_W-1:0];
				CFG_RANGE_HIGH:    cfg_q.range_high    <= cfg_data[VALUE_W-1:0];
				CFG_ALPHA:         cfg_q.alpha         <= cfg_data[ALPHA_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// Front end classifies each word as it is accepted and pushes it into the queue.
	psema_front u_front (
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.opcode     (opcode),
		.raw_sample (raw_sample),
		.cfg        (cfg_q),
		.queue_full (queue_full),
		.push       (push),
		.item       (front_item)
	);

	psema_fifo u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.wr_item (front_item),
		.pop     (pop),
		.full    (queue_full),
		.valid   (queue_valid),
		.rd_item (queue_item)
	);

	// Back end pops one word at a time and owns all filter and period state.
	psema_back u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg            (cfg_q),
		.item_valid     (queue_valid),
		.item           (queue_item),
		.pop            (pop),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.scaled_value   (scaled_value),
		.smoothed_value (smoothed_value),
		.period_average (period_average)
	);

endmodule

### dv/pedal_sensor_scale_ema_average_test.sv
// Self-checking testbench for the pedal scaler with moving-average filter and period average.
`timescale 1ns / 1ps

module pedal_sensor_scale_ema_average_test;
	import psema_pkg::*;

	// A run of this many cycles with no handshake on any channel means the block is stuck.
	// This is ample for the slowest word plus a receiver stall.
	localparam int STALL_LIMIT = 2000;
	// Cycles allowed after the last result for anything stray to show up.
	localparam int SETTLE_CYCLES = 40;
	localparam int MAX_REPORTS = 20;
	// Register index outside the register list; a write to it must change nothing.
	localparam logic [CFG_INDEX_W-1:0] SPARE_INDEX = 3'd7;
	localparam int RAW_MAX = (1 << SAMPLE_BITS) - 1;

	// One expected output word.
	typedef struct packed {
		logic [VALUE_W-1:0] scaled;
		logic [VALUE_W-1:0] filtered;
		logic [VALUE_W-1:0] average;
	} pedal_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic opcode = OP_SAMPLE;
	logic [SAMPLE_BITS-1:0] raw_sample = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [VALUE_W-1:0] scaled_value;
	logic [VALUE_W-1:0] smoothed_value;
	logic [VALUE_W-1:0] period_average;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_INDEX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	// Our own copy of the register file.
	logic [SAMPLE_BITS-1:0] win_zero;
	logic [SAMPLE_BITS-1:0] win_full;
	logic [VALUE_W-1:0] out_low;
	logic [VALUE_W-1:0] out_high;
	logic [ALPHA_W-1:0] ema_weight;

	// Our own copy of the filter and period state.
	logic [ACC_W-1:0] ema_acc;
	logic ema_primed;
	logic [VALUE_W-1:0] held_scaled;
	logic [VALUE_W-1:0] held_filtered;
	logic [SUM_W-1:0] sum_in_period;
	logic [COUNT_W-1:0] samples_in_period;
	logic [VALUE_W-1:0] held_average;

	// Words still owed by the block, oldest first.
	pedal_result_t pending_readings[$];

	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int mismatch_count = 0;
	int results_checked = 0;
	int samples_sent = 0;
	int ticks_sent = 0;
	int settings_loaded = 0;
	int idle_cycles = 0;

	pedal_sensor_scale_ema_average i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.opcode(opcode),
		.raw_sample(raw_sample),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.scaled_value(scaled_value),
		.smoothed_value(smoothed_value),
		.period_average(period_average),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	// ------------------------------------------------------------------
	// Prediction
	// ------------------------------------------------------------------

	task automatic clear_pedal_state();
		win_zero = '0;
		win_full = SAMPLE_BITS'(RAW_MAX);
		out_low = '0;
		out_high = 16'd100;
		ema_weight = 17'd6554;
		ema_acc = '0;
		ema_primed = 1'b0;
		held_scaled = '0;
		held_filtered = '0;
		sum_in_period = '0;
		samples_in_period = '0;
		held_average = '0;
	endtask

	// Writes to indexes outside the register list are dropped, and data bits above a
	// register's width are ignored.
	function automatic void apply_setting(logic [CFG_INDEX_W-1:0] idx,
			logic [CFG_DATA_W-1:0] data);
		case (idx)
			CFG_ZERO_POSITION: win_zero = data[SAMPLE_BITS-1:0];
			CFG_FULL_POSITION: win_full = data[SAMPLE_BITS-1:0];
			CFG_RANGE_LOW:     out_low = data[VALUE_W-1:0];
			CFG_RANGE_HIGH:    out_high = data[VALUE_W-1:0];
			CFG_ALPHA:         ema_weight = data;
			default: ;
		endcase
	endfunction

	// Linear map of an in-window reading. The division truncates toward zero, and a
	// descending output range works through the signed difference.
	function automatic logic [VALUE_W-1:0] map_reading(logic [SAMPLE_BITS-1:0] raw);
		longint span;
		longint zero;
		longint low;
		longint high;
		longint offs;
		longint q;
		span = longint'(win_full);
		zero = longint'(win_zero);
		low = longint'(out_low);
		high = longint'(out_high);
		offs = longint'(raw);
		span = span - zero;
		offs = offs - zero;
		q = '0;
		// A window of width zero gives a quotient of zero, so the result is the low end.
		if (span > 0) begin
			q = (offs * (high - low)) / span;
		end
		q = low + q;
		return q[VALUE_W-1:0];
	endfunction

	// One step of the moving average in 16.16 fixed point. The first in-window sample
	// seeds the accumulator; an alpha above one acts as one.
	function automatic logic [VALUE_W-1:0] ema_next(logic [VALUE_W-1:0] v);
		logic [63:0] shifted;
		logic [63:0] a;
		logic [63:0] acc_wide;
		logic [63:0] mix;
		logic [63:0] rounded;
		shifted = {48'd0, v} << FRAC_W;
		if (!ema_primed) begin
			ema_acc = shifted[ACC_W-1:0];
			ema_primed = 1'b1;
		end else begin
			a = 64'(ema_weight);
			if (a > 64'(ALPHA_ONE)) begin
				a = 64'(ALPHA_ONE);
			end
			acc_wide = {32'd0, ema_acc};
			mix = a * shifted + (64'd65536 - a) * acc_wide + 64'd32768;
			ema_acc = mix[FRAC_W+ACC_W-1:FRAC_W];
		end
		rounded = ({32'd0, ema_acc} + 64'd32768) >> FRAC_W;
		return (rounded > 64'hFFFF) ? 16'hFFFF : rounded[VALUE_W-1:0];
	endfunction

	// Advances our copy of the block by one accepted word and queues the word it owes.
	function automatic void predict_pedal_word(logic op, logic [SAMPLE_BITS-1:0] raw);
		pedal_result_t owed;
		logic [SUM_W-1:0] quotient;
		if (op == OP_SAMPLE) begin
			if (raw >= win_zero && raw <= win_full) begin
				held_scaled = map_reading(raw);
				held_filtered = ema_next(held_scaled);
			end else if (raw < win_zero) begin
				// Below the window both outputs clamp low and the filter is left alone.
				held_scaled = out_low;
				held_filtered = out_low;
			end else begin
				// Everything else outside the window clamps high, filter untouched.
				held_scaled = out_high;
				held_filtered = out_high;
			end
			sum_in_period = sum_in_period + {16'd0, held_scaled};
			samples_in_period = samples_in_period + 8'd1;
			samples_sent++;
		end else begin
			// An empty period averages to zero; a count that wrapped can push the
			// quotient past 16 bits, where it saturates.
			quotient = '0;
			if (samples_in_period != 0) begin
				quotient = sum_in_period / {24'd0, samples_in_period};
			end
			held_average = (quotient > 32'hFFFF) ? 16'hFFFF : quotient[VALUE_W-1:0];
			sum_in_period = '0;
			samples_in_period = '0;
			ticks_sent++;
		end
		owed.scaled = held_scaled;
		owed.filtered = held_filtered;
		owed.average = held_average;
		pending_readings.push_back(owed);
	endfunction

	// ------------------------------------------------------------------
	// Drivers. Each task starts and ends in the time step of a rising edge.
	// ------------------------------------------------------------------

	// Presents one word and waits for it to be taken. Valid stays high from one word to
	// the next unless the sender decides to idle first.
	task automatic send_word(logic op, logic [SAMPLE_BITS-1:0] raw);
		int gap;
		gap = 0;
		while ($urandom_range(99) < send_idle_pct) begin
			gap++;
		end
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		opcode <= op;
		raw_sample <= raw;
		do @(posedge clk); while (!in_ready);
		predict_pedal_word(op, raw);
	endtask

	// Drops valid and waits for every owed word; the block is idle after this.
	task automatic wait_for_drain();
		in_valid <= 1'b0;
		do @(posedge clk); while (pending_readings.size() != 0);
	endtask

	task automatic write_setting(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		apply_setting(idx, data);
	endtask

	// Loads a full register set while the block is idle. The bits above each register's
	// width carry junk, and a write to the spare index goes along as well.
	task automatic load_settings(logic [SAMPLE_BITS-1:0] zero, logic [SAMPLE_BITS-1:0] full,
			logic [VALUE_W-1:0] low, logic [VALUE_W-1:0] high, logic [ALPHA_W-1:0] weight);
		logic [CFG_DATA_W-SAMPLE_BITS-1:0] junk_a;
		logic [CFG_DATA_W-SAMPLE_BITS-1:0] junk_b;
		logic junk_c;
		logic junk_d;
		junk_a = (CFG_DATA_W-SAMPLE_BITS)'($urandom);
		junk_b = (CFG_DATA_W-SAMPLE_BITS)'($urandom);
		junk_c = 1'($urandom);
		junk_d = 1'($urandom);
		wait_for_drain();
		write_setting(SPARE_INDEX, CFG_DATA_W'($urandom));
		write_setting(CFG_ZERO_POSITION, {junk_a, zero});
		write_setting(CFG_FULL_POSITION, {junk_b, full});
		write_setting(CFG_RANGE_LOW, {junk_c, low});
		write_setting(CFG_RANGE_HIGH, {junk_d, high});
		write_setting(CFG_ALPHA, weight);
		cfg_valid <= 1'b0;
		settings_loaded++;
	endtask

	// ------------------------------------------------------------------
	// Checking
	// ------------------------------------------------------------------

	task automatic report_mismatch(string what, logic [VALUE_W-1:0] got,
			logic [VALUE_W-1:0] want);
		if (mismatch_count < MAX_REPORTS) begin
			$display("%0t MISMATCH %s: got %0d, expected %0d (word %0d)", $realtime, what,
				got, want, results_checked);
		end
		mismatch_count++;
	endtask

	// Samples the output at each rising edge and draws the next ready value.
	always @(posedge clk) begin : result_check
		pedal_result_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_readings.size() == 0) begin
				report_mismatch("word with nothing owed, scaled", scaled_value, '0);
			end else begin
				want = pending_readings.pop_front();
				if (scaled_value !== want.scaled) begin
					report_mismatch("scaled_value", scaled_value, want.scaled);
				end
				if (smoothed_value !== want.filtered) begin
					report_mismatch("smoothed_value", smoothed_value, want.filtered);
				end
				if (period_average !== want.average) begin
					report_mismatch("period_average", period_average, want.average);
				end
			end
			results_checked++;
		end
		out_ready <= ($urandom_range(99) >= recv_idle_pct);
	end

	// Ends the run if no channel moves a word for too long.
	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
				(cfg_valid && cfg_ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= STALL_LIMIT) begin
			$display("Watchdog: no handshake for %0d cycles, %0d words still owed",
				idle_cycles, pending_readings.size());
			$display("FAIL");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------

	// Reset values: a tick on an empty period, the first sample seeding the filter,
	// both ends and the middle of the reading range, then a tick that closes a real period.
	task automatic test_reset_defaults();
		send_word(OP_TICK, SAMPLE_BITS'(RAW_MAX));
		send_word(OP_SAMPLE, '0);
		send_word(OP_SAMPLE, SAMPLE_BITS'(RAW_MAX));
		send_word(OP_SAMPLE, 12'd2048);
		send_word(OP_TICK, '0);
	endtask

	// A narrow window: readings below, at both bounds, above, and in the middle. Alpha is
	// exactly one, so the filter follows each in-window sample.
	task automatic test_window_and_clamps();
		load_settings(12'd100, 12'd3000, 16'd1000, 16'd60000, 17'd65536);
		send_word(OP_SAMPLE, '0);
		send_word(OP_SAMPLE, 12'd99);
		send_word(OP_SAMPLE, 12'd100);
		send_word(OP_SAMPLE, 12'd3000);
		send_word(OP_SAMPLE, 12'd3001);
		send_word(OP_SAMPLE, SAMPLE_BITS'(RAW_MAX));
		send_word(OP_SAMPLE, 12'd1550);
		send_word(OP_TICK, 12'd1550);
	endtask

	// Descending output range with alpha above one, a window of width zero with alpha
	// zero, and a window whose bounds are swapped so that nothing lies inside.
	task automatic test_odd_settings();
		load_settings('0, SAMPLE_BITS'(RAW_MAX), 16'hFFFF, '0, 17'h1FFFF);
		send_word(OP_SAMPLE, SAMPLE_BITS'(RAW_MAX));
		send_word(OP_SAMPLE, '0);
		send_word(OP_SAMPLE, 12'd1234);
		send_word(OP_TICK, '0);
		load_settings(12'd2000, 12'd2000, 16'd500, 16'd40000, '0);
		send_word(OP_SAMPLE, 12'd2000);
		send_word(OP_SAMPLE, 12'd1999);
		send_word(OP_SAMPLE, 12'd2001);
		load_settings(12'd3000, 12'd1000, 16'd7, 16'd65535, 17'd30000);
		send_word(OP_SAMPLE, 12'd2000);
		send_word(OP_SAMPLE, 12'd500);
		send_word(OP_TICK, 12'd4000);
	endtask

	// Random traffic under one idle pattern. Each block of words runs under a fresh
	// register set, and halfway through a block the sender holds off until every owed
	// word is back. Periods are mostly short, sometimes empty, and now and then 255 to 262
	// samples so that the count can wrap and the average saturate or drop to zero.
	task automatic test_random_traffic(int sender_pct, int receiver_pct, int words);
		int sent;
		int chunk;
		int period_left;
		logic [SAMPLE_BITS-1:0] zero;
		logic [SAMPLE_BITS-1:0] full;
		logic [VALUE_W-1:0] low;
		logic [VALUE_W-1:0] high;
		logic [ALPHA_W-1:0] weight;
		logic [SAMPLE_BITS-1:0] raw;
		send_idle_pct = sender_pct;
		recv_idle_pct = receiver_pct;
		sent = 0;
		period_left = $urandom_range(1, 20);
		while (sent < words) begin
			case ($urandom_range(7))
				0: zero = '0;
				1: zero = SAMPLE_BITS'(RAW_MAX);
				default: zero = SAMPLE_BITS'($urandom_range(RAW_MAX));
			endcase
			case ($urandom_range(9))
				0: full = SAMPLE_BITS'(RAW_MAX);
				1: full = zero;
				2: full = SAMPLE_BITS'($urandom_range(RAW_MAX));
				default: full = SAMPLE_BITS'($urandom_range(RAW_MAX, zero));
			endcase
			case ($urandom_range(5))
				0: low = '0;
				1: low = 16'hFFFF;
				default: low = VALUE_W'($urandom);
			endcase
			case ($urandom_range(5))
				0: high = '0;
				1: high = 16'hFFFF;
				default: high = VALUE_W'($urandom);
			endcase
			case ($urandom_range(7))
				0: weight = '0;
				1: weight = ALPHA_W'(ALPHA_ONE);
				2: weight = ALPHA_W'($urandom_range(17'h1FFFF, ALPHA_ONE + 1));
				default: weight = ALPHA_W'($urandom_range(ALPHA_ONE));
			endcase
			load_settings(zero, full, low, high, weight);
			chunk = $urandom_range(100, 200);
			for (int i = 0; i < chunk && sent < words; i++) begin
				if (i == chunk / 2) begin
					wait_for_drain();
				end
				if (period_left == 0) begin
					send_word(OP_TICK, SAMPLE_BITS'($urandom_range(RAW_MAX)));
					case ($urandom_range(19))
						0, 1: period_left = 0;
						2: period_left = $urandom_range(262, 255);
						default: period_left = $urandom_range(20, 1);
					endcase
				end else begin
					case ($urandom_range(9))
						0: raw = '0;
						1: raw = SAMPLE_BITS'(RAW_MAX);
						2: raw = (win_zero > 0) ?
							SAMPLE_BITS'($urandom_range(win_zero - 1, 0)) : '0;
						3: raw = (win_full < RAW_MAX) ?
							SAMPLE_BITS'($urandom_range(RAW_MAX, win_full + 1)) :
							SAMPLE_BITS'(RAW_MAX);
						4: raw = SAMPLE_BITS'($urandom_range(RAW_MAX));
						default: raw = (win_zero <= win_full) ?
							SAMPLE_BITS'($urandom_range(win_full, win_zero)) :
							SAMPLE_BITS'($urandom_range(RAW_MAX));
					endcase
					send_word(OP_SAMPLE, raw);
					period_left--;
				end
				sent++;
			end
		end
	endtask

	initial begin
		clear_pedal_state();
		send_idle_pct = 12;
		recv_idle_pct = 56;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		test_reset_defaults();
		test_window_and_clamps();
		test_odd_settings();
		test_random_traffic(12, 56, 610);
		test_random_traffic(56, 12, 610);
		test_random_traffic(0, 0, 610);

		// Everything is sent; wait for the last owed word, then watch for strays.
		wait_for_drain();
		repeat (SETTLE_CYCLES) @(posedge clk);

		$display("Covered %0d samples and %0d ticks under %0d register sets, %0d words checked.",
			samples_sent, ticks_sent, settings_loaded, results_checked);
		$display("Idle patterns: sender 12%% / receiver 56%%, the reverse, then none; %0d mismatches.",
			mismatch_count);
		if (mismatch_count == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule
